@@ hw/rtl/tclp_pkg.sv @@
// ----------------------------------------------------------------------------
// tclp_pkg
// Types, codes and constants shared by the text command line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

    // Line length limit: the byte that would be number LINE_LIMIT is refused
    localparam int LINE_LIMIT = 64;
    localparam int LEN_W      = $clog2(LINE_LIMIT);

    localparam int ARG_SLOTS = 3;
    localparam int DATA_W    = 120;

    localparam logic [29:0] MANT_MAX = 30'd999999999;
    localparam logic [2:0]  TOK_MAX  = 3'd4;
    localparam logic [3:0]  SCL_MAX  = 4'd9;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'd32;

    // Keyword tracker; the first ten codes double as command codes
    typedef enum logic [3:0] {
        KW_P     = 4'd0,
        KW_PL    = 4'd1,
        KW_PR    = 4'd2,
        KW_R     = 4'd3,
        KW_S     = 4'd4,
        KW_G     = 4'd5,
        KW_GA    = 4'd6,
        KW_YM    = 4'd7,
        KW_YQ    = 4'd8,
        KW_Q     = 4'd9,
        KW_NONE  = 4'd10,
        KW_Y     = 4'd11,
        KW_EMPTY = 4'd12
    } kw_t;

    localparam logic [3:0] CMD_NONE = 4'd10;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_SIGN    = 3'd1,
        PH_INT     = 3'd2,
        PH_DOTONLY = 3'd3,
        PH_FRAC    = 3'd4,
        PH_BAD     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FORMAT   = 3'd1,
        ST_RANGE    = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0]                 len;
        logic [2:0]                       tok;
        logic                             in_tok;
        logic                             cut;
        kw_t                              kw;
        phase_t                           phase;
        logic [29:0]                      acc;
        logic [3:0]                       acc_scale;
        logic                             neg;
        logic [ARG_SLOTS-1:0][30:0]       arg_mant;
        logic [ARG_SLOTS-1:0][3:0]        arg_scale;
        logic [ARG_SLOTS-1:0]             arg_valid;
    } line_state_t;

    typedef struct packed {
        logic [3:0]                       cmd;
        status_t                          status;
        logic [ARG_SLOTS-1:0][30:0]       mant;
        logic [ARG_SLOTS-1:0][3:0]        scl;
        logic [1:0]                       yaw;
    } result_t;

    localparam line_state_t LINE_CLEAR = '{
        len:       '0,
        tok:       '0,
        in_tok:    1'b0,
        cut:       1'b0,
        kw:        KW_NONE,
        phase:     PH_START,
        acc:       '0,
        acc_scale: '0,
        neg:       1'b0,
        arg_mant:  '0,
        arg_scale: '0,
        arg_valid: '0
    };

endpackage

@@ hw/rtl/tclp_finish.sv @@
// ----------------------------------------------------------------------------
// tclp_finish
// Line end evaluation: command lookup, argument count and YM range check.
// ----------------------------------------------------------------------------
module tclp_finish (
    input  tclp_pkg::line_state_t st,
    output logic                  fin_valid,
    output tclp_pkg::result_t     fin_res
);
    import tclp_pkg::*;

    function automatic logic [1:0] args_needed(kw_t k);
        logic [1:0] n;
        case (k) inside
            KW_P, KW_PL, KW_PR: n = 2'd3;
            KW_R:               n = 2'd2;
            KW_G, KW_GA, KW_YM: n = 2'd1;
            default:            n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] pow_ten(logic [3:0] s);
        logic [31:0] p;
        case (s)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            default: p = 32'd1000000000;
        endcase
        return p;
    endfunction

    logic [1:0]  need;
    logic        args_bad;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] ym_m;
    logic        ym_bad;
    logic [1:0]  ym_ip;

    always_comb begin
        need     = args_needed(st.kw);
        args_bad = 1'b0;
        for (int i = 0; i < ARG_SLOTS; i++) begin
            if (i < int'(need) && !st.arg_valid[i]) begin
                args_bad = 1'b1;
            end
        end

        // Value in [0,3] means mantissa <= 3 * 10^scale; negative has bit 30 set
        p1     = pow_ten(st.arg_scale[0]);
        p2     = {p1[30:0], 1'b0};
        p3     = p1 + p2;
        ym_m   = {1'b0, st.arg_mant[0]};
        ym_bad = st.arg_mant[0][30] || (ym_m > p3);
        if (ym_m >= p3) begin
            ym_ip = 2'd3;
        end else if (ym_m >= p2) begin
            ym_ip = 2'd2;
        end else if (ym_m >= p1) begin
            ym_ip = 2'd1;
        end else begin
            ym_ip = 2'd0;
        end

        fin_valid = (st.tok != 3'd0);
        fin_res   = '0;
        if (4'(st.kw) > 4'(KW_Q)) begin
            fin_res.cmd    = CMD_NONE;
            fin_res.status = ST_UNKNOWN;
        end else begin
            fin_res.cmd = 4'(st.kw);
            if (args_bad) begin
                fin_res.status = ST_FORMAT;
            end else if (st.kw == KW_YM && ym_bad) begin
                fin_res.status = ST_RANGE;
            end else begin
                fin_res.status = ST_OK;
                for (int i = 0; i < ARG_SLOTS; i++) begin
                    if (i < int'(need)) begin
                        fin_res.mant[i] = st.arg_mant[i];
                        fin_res.scl[i]  = st.arg_scale[i];
                    end
                end
                if (st.kw == KW_YM) begin
                    fin_res.yaw = ym_ip;
                end
            end
        end
    end

endmodule

@@ hw/rtl/tclp_core.sv @@
// ----------------------------------------------------------------------------
// tclp_core
// Per-byte line state update: tokenizer, keyword matcher, number scanner.
// ----------------------------------------------------------------------------
module tclp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output tclp_pkg::result_t res
);
    import tclp_pkg::*;

    function automatic kw_t kw_step(kw_t k, logic [7:0] c);
        logic [7:0] u;
        kw_t        nk;
        u  = (c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_FOLD : c;
        nk = KW_NONE;
        case (k)
            KW_EMPTY: begin
                case (u)
                    "P":     nk = KW_P;
                    "R":     nk = KW_R;
                    "S":     nk = KW_S;
                    "G":     nk = KW_G;
                    "Y":     nk = KW_Y;
                    "Q":     nk = KW_Q;
                    default: nk = KW_NONE;
                endcase
            end
            KW_P: begin
                if (u == "L") nk = KW_PL;
                else if (u == "R") nk = KW_PR;
            end
            KW_G: begin
                if (u == "A") nk = KW_GA;
            end
            KW_Y: begin
                if (u == "M") nk = KW_YM;
                else if (u == "Q") nk = KW_YQ;
            end
            default: nk = KW_NONE;
        endcase
        return nk;
    endfunction

    line_state_t state_reg;
    line_state_t state_next;
    line_state_t ets;
    line_state_t fed;
    logic        fin_valid;
    result_t     fin_res;

    logic        is_eol;
    logic        is_blank;
    logic [1:0]  idx;
    logic        arg_ok;
    logic [30:0] arg_m;
    logic        dig;
    logic [3:0]  d;
    phase_t      phase0;
    logic [29:0] acc0;
    logic [3:0]  sc0;
    logic [33:0] nxt;
    logic        frac_ok;

    tclp_finish u_finish (
        .st        (ets),
        .fin_valid (fin_valid),
        .fin_res   (fin_res)
    );

    // Close the open token, storing it as an argument where it is one
    always_comb begin
        ets    = state_reg;
        idx    = 2'(state_reg.tok - 3'd1);
        arg_ok = (state_reg.phase == PH_INT) || (state_reg.phase == PH_FRAC);
        arg_m  = arg_ok ? {1'b0, state_reg.acc} : 31'd0;
        if (state_reg.in_tok) begin
            if (state_reg.tok >= 3'd1 && state_reg.tok <= 3'd3) begin
                ets.arg_valid[idx] = arg_ok;
                ets.arg_mant[idx]  = state_reg.neg ? 31'd0 - arg_m : arg_m;
                ets.arg_scale[idx] = arg_ok ? state_reg.acc_scale : 4'd0;
            end
            if (state_reg.tok < TOK_MAX) begin
                ets.tok = state_reg.tok + 3'd1;
            end
            ets.in_tok = 1'b0;
        end
    end

    // Feed one non-blank byte into the current token
    always_comb begin
        fed        = state_reg;
        fed.in_tok = 1'b1;
        dig        = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
        d          = dig ? 4'(rx_byte - CHAR_ZERO) : 4'd0;
        phase0     = state_reg.phase;
        acc0       = state_reg.acc;
        sc0        = state_reg.acc_scale;
        if (!state_reg.in_tok && state_reg.tok != 3'd0) begin
            phase0  = PH_START;
            acc0    = '0;
            sc0     = '0;
            fed.neg = 1'b0;
        end
        fed.phase     = phase0;
        fed.acc       = acc0;
        fed.acc_scale = sc0;

        nxt     = 34'(acc0) * 34'd10 + 34'(d);
        frac_ok = (sc0 < SCL_MAX) && (nxt <= 34'(MANT_MAX));

        if (state_reg.tok == 3'd0) begin
            fed.kw = kw_step(state_reg.in_tok ? state_reg.kw : KW_EMPTY, rx_byte);
        end else if (state_reg.tok <= 3'd3) begin
            unique case (phase0) inside
                PH_START, PH_SIGN, PH_INT: begin
                    if (dig) begin
                        fed.acc   = (nxt > 34'(MANT_MAX)) ? MANT_MAX : nxt[29:0];
                        fed.phase = PH_INT;
                    end else if (rx_byte == CHAR_DOT) begin
                        fed.phase = (phase0 == PH_INT) ? PH_FRAC : PH_DOTONLY;
                    end else if (phase0 == PH_START && rx_byte == CHAR_MINUS) begin
                        fed.neg   = 1'b1;
                        fed.phase = PH_SIGN;
                    end else if (phase0 == PH_START && rx_byte == CHAR_PLUS) begin
                        fed.phase = PH_SIGN;
                    end else begin
                        fed.phase = PH_BAD;
                    end
                end
                PH_DOTONLY, PH_FRAC: begin
                    if (dig) begin
                        fed.phase = PH_FRAC;
                        if (frac_ok) begin
                            fed.acc       = nxt[29:0];
                            fed.acc_scale = sc0 + 4'd1;
                        end
                    end else begin
                        fed.phase = PH_BAD;
                    end
                end
                default: fed.phase = PH_BAD;
            endcase
        end
    end

    always_comb begin
        is_eol     = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
        is_blank   = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB);
        state_next = state_reg;
        res_valid  = 1'b0;
        res        = fin_res;
        if (step) begin
            if (is_eol) begin
                if (state_reg.len != '0) begin
                    res_valid  = fin_valid;
                    state_next = LINE_CLEAR;
                end
            end else if (state_reg.len < LEN_W'(LINE_LIMIT - 1)) begin
                if (!state_reg.cut) begin
                    if (rx_byte == CHAR_NUL) begin
                        state_next     = ets;
                        state_next.cut = 1'b1;
                    end else if (is_blank) begin
                        state_next = ets;
                    end else begin
                        state_next = fed;
                    end
                end
                state_next.len = state_reg.len + LEN_W'(1);
            end else begin
                state_next = LINE_CLEAR;
                res_valid  = 1'b1;
                res        = '0;
                res.cmd    = CMD_NONE;
                res.status = ST_TOO_LONG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LINE_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/text_command_line_parser_unit.sv @@
// ----------------------------------------------------------------------------
// text_command_line_parser_unit
// Byte-stream command line parser with registered input and result stages.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one received character per request in s_tdata.
//   Lines end on CR or LF; each non-empty line yields at most one request
//   on the m_ channel carrying command code, status and up to three
//   arguments as signed decimal mantissa plus fraction digit count.
//   A line that reaches the length limit yields a too-long request at once
//   and parsing restarts on the next byte.
// Throughput and stages:
//   One byte per cycle while the result register is free or draining.
//   A byte waits in the input register, then the line state update and
//   the line end evaluation run in a single combinational step into the
//   result register, which drives m_tvalid once the line end byte has
//   passed through the input register.
// Reset and stall:
//   aresetn (synchronous, active low) clears both stage valid flags and the
//   line state. While m_tready is low and a result waits, the input stage
//   holds its byte and s_tready drops once that stage is full; no request
//   is lost or repeated.
// ----------------------------------------------------------------------------
module text_command_line_parser_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: [7:0] rx_byte
    input  logic [7:0]                  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: [3:0] command, [6:4] status, [37:7] first_mantissa,
    //   [41:38] first_scale, [72:42] second_mantissa, [76:73] second_scale,
    //   [107:77] third_mantissa, [111:108] third_scale, [113:112] yaw_mode,
    //   [119:114] zero
    output logic [tclp_pkg::DATA_W-1:0] m_tdata
);
    import tclp_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic [7:0]        in_byte_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;

    logic    fire;
    logic    s_take;
    logic    res_valid;
    result_t res;

    // Advance the held byte whenever the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_take   = s_tvalid && s_tready;

    tclp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire && res_valid) begin
            out_valid_next = 1'b1;
            out_data_next  = {6'd0, res.yaw,
                              res.scl[2], res.mant[2],
                              res.scl[1], res.mant[1],
                              res.scl[0], res.mant[0],
                              res.status, res.cmd};
        end else if (m_tready) begin
            // drop the delivered result
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text command line parser.
// Drives characters on the s_ stream and predicts each line's result request
// with an in-bench parser. A small scoreboard checks every m_ request field
// by field. The stimulus starts with directed lines: each command, the error
// cases, a zero-byte cut, blank lines and a too-long line. Random lines
// follow over four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
    import tclp_pkg::*;

    // Predicted result request, one per evaluated line
    typedef struct packed {
        logic [3:0]       cmd;
        logic [2:0]       status;
        logic [2:0][30:0] mant;
        logic [2:0][3:0]  scl;
        logic [1:0]       yaw;
    } line_result_t;

    class line_parse_scoreboard;
        int unsigned  line_len;
        int unsigned  tok_idx;
        bit           in_tok;
        bit           cut;
        kw_t          kw;
        phase_t       phase;
        int unsigned  acc;
        int unsigned  acc_scl;
        bit           neg;
        logic [30:0]  slot_mant [3];
        logic [3:0]   slot_scl [3];
        bit           slot_ok [3];
        line_result_t expected_lines [$];
        int unsigned  fails;

        function new();
            fails = 0;
            clear_line();
        endfunction

        static function int unsigned arg_count(kw_t k);
            case (k) inside
                KW_P, KW_PL, KW_PR: return 3;
                KW_R:               return 2;
                KW_G, KW_GA, KW_YM: return 1;
                default:            return 0;
            endcase
        endfunction

        function void clear_line();
            line_len = 0;
            tok_idx  = 0;
            in_tok   = 1'b0;
            cut      = 1'b0;
            kw       = KW_NONE;
            phase    = PH_START;
            acc      = 0;
            acc_scl  = 0;
            neg      = 1'b0;
            for (int i = 0; i < 3; i++) begin
                slot_mant[i] = '0;
                slot_scl[i]  = '0;
                slot_ok[i]   = 1'b0;
            end
        endfunction

        // Store the finished number token in its argument slot
        function void close_token();
            logic [30:0] mag;
            bit          ok;
            if (!in_tok) return;
            if (tok_idx >= 1 && tok_idx <= 3) begin
                ok = (phase == PH_INT) || (phase == PH_FRAC);
                mag = ok ? 31'(acc) : 31'd0;
                slot_ok[tok_idx - 1]   = ok;
                slot_mant[tok_idx - 1] = neg ? 31'd0 - mag : mag;
                slot_scl[tok_idx - 1]  = ok ? 4'(acc_scl) : 4'd0;
            end
            if (tok_idx < 4) tok_idx++;
            in_tok = 1'b0;
        endfunction

        function void fold_keyword(logic [7:0] c);
            logic [7:0] u;
            kw_t        nxt;
            u = (c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_FOLD : c;
            nxt = KW_NONE;
            case (kw)
                KW_EMPTY: begin
                    case (u)
                        "P": nxt = KW_P;
                        "R": nxt = KW_R;
                        "S": nxt = KW_S;
                        "G": nxt = KW_G;
                        "Y": nxt = KW_Y;
                        "Q": nxt = KW_Q;
                        default: nxt = KW_NONE;
                    endcase
                end
                KW_P: begin
                    if (u == "L") nxt = KW_PL;
                    else if (u == "R") nxt = KW_PR;
                end
                KW_G: begin
                    if (u == "A") nxt = KW_GA;
                end
                KW_Y: begin
                    if (u == "M") nxt = KW_YM;
                    else if (u == "Q") nxt = KW_YQ;
                end
                default: nxt = KW_NONE;
            endcase
            kw = nxt;
        endfunction

        // Integer digits saturate; fraction digits drop once nine are kept
        // or the mantissa would overflow
        function void push_digit(int unsigned d, bit frac);
            longint unsigned nxt;
            nxt = longint'(acc) * 10 + d;
            if (!frac) begin
                acc = (nxt > MANT_MAX) ? int'(MANT_MAX) : int'(nxt);
            end else if (acc_scl < SCL_MAX && nxt <= MANT_MAX) begin
                acc = int'(nxt);
                acc_scl++;
            end
        endfunction

        function void step_number(logic [7:0] c);
            bit          dig;
            int unsigned d;
            dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
            d = dig ? int'(c - CHAR_ZERO) : 0;
            case (phase) inside
                PH_START: begin
                    if (c == CHAR_MINUS) begin
                        neg = 1'b1;
                        phase = PH_SIGN;
                    end else if (c == CHAR_PLUS) begin
                        phase = PH_SIGN;
                    end else if (dig) begin
                        push_digit(d, 1'b0);
                        phase = PH_INT;
                    end else if (c == CHAR_DOT) begin
                        phase = PH_DOTONLY;
                    end else begin
                        phase = PH_BAD;
                    end
                end
                PH_SIGN, PH_INT: begin
                    if (dig) begin
                        push_digit(d, 1'b0);
                        phase = PH_INT;
                    end else if (c == CHAR_DOT) begin
                        phase = (phase == PH_INT) ? PH_FRAC : PH_DOTONLY;
                    end else begin
                        phase = PH_BAD;
                    end
                end
                PH_DOTONLY, PH_FRAC: begin
                    if (dig) begin
                        push_digit(d, 1'b1);
                        phase = PH_FRAC;
                    end else begin
                        phase = PH_BAD;
                    end
                end
                default: phase = PH_BAD;
            endcase
        endfunction

        function void feed_byte(logic [7:0] c);
            if (c == CHAR_SPACE || c == CHAR_TAB) begin
                close_token();
                return;
            end
            if (!in_tok) begin
                in_tok = 1'b1;
                if (tok_idx == 0) begin
                    kw = KW_EMPTY;
                end else begin
                    phase   = PH_START;
                    acc     = 0;
                    acc_scl = 0;
                    neg     = 1'b0;
                end
            end
            if (tok_idx == 0) fold_keyword(c);
            else if (tok_idx <= 3) step_number(c);
        endfunction

        // Evaluate the line at its end; returns 0 for a line with no token
        function bit evaluate_line(output line_result_t res);
            int unsigned     need;
            longint unsigned divisor;
            longint unsigned whole;
            longint unsigned rest;
            res = '0;
            close_token();
            if (tok_idx == 0) return 1'b0;
            if (kw > KW_Q) begin
                res.cmd = CMD_NONE;
                res.status = ST_UNKNOWN;
                return 1'b1;
            end
            res.cmd = kw;
            need = arg_count(kw);
            for (int i = 0; i < need; i++) begin
                if (!slot_ok[i]) begin
                    res.status = ST_FORMAT;
                    return 1'b1;
                end
            end
            if (kw == KW_YM) begin
                // negative values carry bit 30; minus zero stays zero
                if (slot_mant[0][30]) begin
                    res.status = ST_RANGE;
                    return 1'b1;
                end
                divisor = 1;
                repeat (slot_scl[0]) divisor = divisor * 10;
                whole = longint'(slot_mant[0]) / divisor;
                rest  = longint'(slot_mant[0]) % divisor;
                if (whole > 3 || (whole == 3 && rest != 0)) begin
                    res.status = ST_RANGE;
                    return 1'b1;
                end
                res.yaw = 2'(whole);
            end
            res.status = ST_OK;
            for (int i = 0; i < need; i++) begin
                res.mant[i] = slot_mant[i];
                res.scl[i]  = slot_scl[i];
            end
            return 1'b1;
        endfunction

        // Note one accepted character request and queue any result it causes
        function void note_byte(logic [7:0] b);
            line_result_t res;
            if (b == CHAR_CR || b == CHAR_LF) begin
                if (line_len > 0) begin
                    if (evaluate_line(res)) expected_lines.push_back(res);
                    clear_line();
                end
            end else if (line_len < LINE_LIMIT - 1) begin
                line_len++;
                if (!cut) begin
                    if (b == CHAR_NUL) begin
                        close_token();
                        cut = 1'b1;
                    end else begin
                        feed_byte(b);
                    end
                end
            end else begin
                clear_line();
                res = '0;
                res.cmd = CMD_NONE;
                res.status = ST_TOO_LONG;
                expected_lines.push_back(res);
            end
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                fails++;
                if (fails <= 10)
                    $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] d);
            line_result_t want;
            if (expected_lines.size() == 0) begin
                fails++;
                if (fails <= 10) $display("result request with none expected: %h", d);
                return;
            end
            want = expected_lines.pop_front();
            compare("command", 32'(want.cmd), 32'(d[3:0]));
            compare("status", 32'(want.status), 32'(d[6:4]));
            for (int i = 0; i < 3; i++) begin
                compare($sformatf("mantissa %0d", i), 32'(want.mant[i]), 32'(d[7 + 35 * i +: 31]));
                compare($sformatf("scale %0d", i), 32'(want.scl[i]), 32'(d[38 + 35 * i +: 4]));
            end
            compare("yaw_mode", 32'(want.yaw), 32'(d[113:112]));
            compare("padding", 32'd0, 32'(d[DATA_W-1:114]));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'd0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;

    line_parse_scoreboard board;
    int unsigned          send_idle_pct  = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          bytes_sent     = 0;
    logic [7:0]           line_buf [$];
    string                cmd_words [10] = '{"P", "PL", "PR", "R", "S", "G", "GA", "YM", "YQ", "Q"};

    text_command_line_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sample both handshakes with the values held before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_byte(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
        end
    end

    // Stall the result side at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one character, idling first at the current rate, and hold it
    // until the request is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line(input string s, input logic [7:0] term);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(term);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.expected_lines.size() != 0) @(posedge aclk);
    endtask

    function automatic void put_sep();
        int n = $urandom_range(3, 1);
        repeat (n) line_buf.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    // Randomize letter case of a word
    function automatic void put_word(string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if ($urandom_range(1)) c = c + CASE_FOLD;
            line_buf.push_back(c);
        end
    endfunction

    function automatic void put_digits(int n, int top);
        repeat (n) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(top)));
    endfunction

    // Signed decimal with random shape; narrow keeps values near the yaw range
    function automatic void put_number(bit narrow);
        int r = $urandom_range(99);
        int n;
        if (r < 15) line_buf.push_back(CHAR_MINUS);
        else if (r < 22) line_buf.push_back(CHAR_PLUS);
        r = $urandom_range(99);
        if (narrow) n = (r < 8) ? 0 : 1;
        else n = (r < 6) ? 0 : (r < 14) ? $urandom_range(12, 9) : $urandom_range(4, 1);
        put_digits(n, (narrow && r < 80) ? 4 : 9);
        r = $urandom_range(99);
        if (r < 40 || n == 0) begin
            line_buf.push_back(CHAR_DOT);
            if (narrow) put_digits($urandom_range(2), (r < 20) ? 0 : 9);
            else put_digits((r < 8) ? $urandom_range(12, 9) : $urandom_range(3), 9);
        end
        if ($urandom_range(99) < 6) line_buf.push_back(8'($urandom_range(8'h7E, 8'h21)));
    endfunction

    function automatic void put_command();
        int unsigned k = $urandom_range(9);
        int unsigned nargs = line_parse_scoreboard::arg_count(kw_t'(k));
        int r = $urandom_range(99);
        if ($urandom_range(99) < 20) put_sep();
        put_word(cmd_words[k]);
        if (r >= 90) nargs = (nargs > 0) ? nargs - 1 : 0;
        else if (r >= 75) nargs = nargs + $urandom_range(2, 1);
        repeat (nargs) begin
            put_sep();
            put_number(k == KW_YM);
        end
        if ($urandom_range(99) < 20) put_sep();
    endfunction

    task automatic send_random_line();
        int r = $urandom_range(99);
        line_buf.delete();
        if (r < 68) begin
            put_command();
        end else if (r < 74) begin
            // unknown word, sometimes with arguments
            repeat ($urandom_range(4, 1)) line_buf.push_back(8'($urandom_range("Z", "A")));
            if ($urandom_range(1)) begin
                put_sep();
                put_number(1'b0);
            end
        end else if (r < 79) begin
            // empty or blank line
            if ($urandom_range(1)) put_sep();
        end else if (r < 85) begin
            // zero byte cuts the content somewhere
            put_command();
            line_buf.insert($urandom_range(line_buf.size()), CHAR_NUL);
        end else if (r < 93) begin
            repeat ($urandom_range(20, 1)) line_buf.push_back(8'($urandom_range(255)));
        end else if (r < 96) begin
            // approach or overrun the line limit, sometimes twice
            repeat ($urandom_range(2 * LINE_LIMIT, LINE_LIMIT - 4))
                line_buf.push_back(8'($urandom_range(8'h7E, 8'h20)));
        end else begin
            // high byte inside a command word
            put_word(cmd_words[$urandom_range(9)]);
            line_buf.insert($urandom_range(line_buf.size()), 8'($urandom_range(255, 128)));
            put_sep();
            put_number(1'b0);
        end
        r = $urandom_range(99);
        if (r < 45) begin
            line_buf.push_back(CHAR_CR);
        end else if (r < 80) begin
            line_buf.push_back(CHAR_LF);
        end else begin
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end
        foreach (line_buf[i]) send_byte(line_buf[i]);
    endtask

    initial begin
        int unsigned idle_plan [4];
        int unsigned stall_plan [4];
        int unsigned target;
        idle_plan  = '{0, 78, 0, 21};
        stall_plan = '{0, 0, 78, 21};
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines: every command, error kinds, cut and limit cases
        send_line("S", CHAR_CR);
        send_line("q", CHAR_LF);
        send_line("Yq", CHAR_CR);
        send_line("G 12", CHAR_CR);
        send_line("ga\t-0.75", CHAR_LF);
        send_line("R 1 -2", CHAR_CR);
        send_line("P 1 2 3", CHAR_CR);
        send_line("pL 123456789012 0.1234567891 -7", CHAR_CR);
        send_line("PR 1 2", CHAR_CR);
        send_line("YM 3", CHAR_CR);
        send_line("ym 3.5", CHAR_CR);
        send_line("YM -0", CHAR_CR);
        send_line("ym -1", CHAR_CR);
        send_line("yM +2.99", CHAR_CR);
        send_line("GX 1", CHAR_CR);
        send_line("G 1.2.3", CHAR_CR);
        send_line("G 12", CHAR_NUL);
        send_line("junk", CHAR_CR);
        send_line("", CHAR_CR);
        send_line(" \t ", CHAR_LF);
        send_line("G .5 extra x", CHAR_CR);
        send_line("G -", CHAR_CR);
        send_line("G 99999999.99", CHAR_CR);
        send_byte(8'hFF);
        send_line("S", CHAR_CR);
        repeat (LINE_LIMIT + 2) send_byte("a");
        send_byte(CHAR_LF);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            target = bytes_sent + 210;
            while (bytes_sent < target) send_random_line();
            drain_results();
        end

        // Allow for the two-stage pipeline before calling the run
        repeat (8) @(posedge aclk);
        if (board.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
